FILE: rtl/bdpc_pkg.sv
// Shared types and constants for the button debounce / press classifier.
// Request and response payload structs, configuration struct, register indexes, defaults.
// No dependencies.
package bdpc_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned CfgIdxWidth      = 2;
  localparam int unsigned CfgDataWidth     = 16;

  localparam logic [CfgIdxWidth-1:0] CFG_IDX_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_IDX_LONG       = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_IDX_EXTRA_LONG = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_IDX_LEVEL      = 2'd3;

  localparam logic [15:0] DEBOUNCE_MS_RST     = 16'd20;
  localparam logic [15:0] LONG_PRESS_MS_RST   = 16'd1000;
  localparam logic [15:0] XLONG_PRESS_MS_RST  = 16'd3000;
  localparam logic        PRESSED_LEVEL_RST   = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE       = 2'd0,
    KIND_SHORT      = 2'd1,
    KIND_LONG       = 2'd2,
    KIND_EXTRA_LONG = 2'd3
  } press_kind_e;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } bdpc_req_t;

  typedef struct packed {
    logic        pressed;
    logic [1:0]  press_kind;
  } bdpc_rsp_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] extra_long_press_ms;
    logic        pressed_level;
  } bdpc_cfg_t;

endpackage

FILE: rtl/bdpc_cfg_regs.sv
// Configuration register file for the press classifier.
// Uses bdpc_pkg for register indexes, reset values and the config struct.
module bdpc_cfg_regs
  import bdpc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  output bdpc_cfg_t               cfg_o
);

  bdpc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_DEBOUNCE:   cfg_d.debounce_ms         = cfg_wdata_i;
        CFG_IDX_LONG:       cfg_d.long_press_ms       = cfg_wdata_i;
        CFG_IDX_EXTRA_LONG: cfg_d.extra_long_press_ms = cfg_wdata_i;
        CFG_IDX_LEVEL:      cfg_d.pressed_level       = cfg_wdata_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms         <= DEBOUNCE_MS_RST;
      cfg_q.long_press_ms       <= LONG_PRESS_MS_RST;
      cfg_q.extra_long_press_ms <= XLONG_PRESS_MS_RST;
      cfg_q.pressed_level       <= PRESSED_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/bdpc_core.sv
// Debounce state machine and press-length classification for one request.
// Uses bdpc_pkg; state updates only on step_i, result is combinational.
module bdpc_core
  import bdpc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  bdpc_req_t req_i,
  input  bdpc_cfg_t cfg_i,
  output bdpc_rsp_t rsp_o
);

  logic                  acc_q, acc_d;
  logic                  prior_q, prior_d;
  logic                  in_deb_q, in_deb_d;
  logic [TIME_WIDTH-1:0] deb_start_q, deb_start_d;
  logic [TIME_WIDTH-1:0] press_start_q, press_start_d;

  logic                  flag;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] deb_elapsed;
  logic [TIME_WIDTH-1:0] held;
  press_kind_e           kind;

  assign flag        = (req_i.pin_level == cfg_i.pressed_level);
  assign now         = TIME_WIDTH'(req_i.now_ms);
  assign deb_elapsed = now - deb_start_q;
  assign held        = now - press_start_q;

  always_comb begin
    acc_d         = acc_q;
    prior_d       = prior_q;
    in_deb_d      = in_deb_q;
    deb_start_d   = deb_start_q;
    press_start_d = press_start_q;
    kind          = KIND_NONE;

    if ((flag != acc_q) && !in_deb_q) begin
      in_deb_d    = 1'b1;
      deb_start_d = now;
    end else if (in_deb_q && (deb_elapsed < TIME_WIDTH'(cfg_i.debounce_ms))) begin
      if (flag == acc_q) begin
        in_deb_d = 1'b0;
      end
    end else begin
      in_deb_d = 1'b0;
      prior_d  = acc_q;
      acc_d    = flag;
    end

    // edge persists while prior lags accepted
    if (acc_d && !prior_d) begin
      press_start_d = now;
    end else if (!acc_d && prior_d) begin
      if (held > TIME_WIDTH'(cfg_i.extra_long_press_ms)) begin
        kind = KIND_EXTRA_LONG;
      end else if (held > TIME_WIDTH'(cfg_i.long_press_ms)) begin
        kind = KIND_LONG;
      end else begin
        kind = KIND_SHORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= 1'b0;
      prior_q       <= 1'b0;
      in_deb_q      <= 1'b0;
      deb_start_q   <= '0;
      press_start_q <= '0;
    end else if (step_i) begin
      acc_q         <= acc_d;
      prior_q       <= prior_d;
      in_deb_q      <= in_deb_d;
      deb_start_q   <= deb_start_d;
      press_start_q <= press_start_d;
    end
  end

  assign rsp_o.pressed    = acc_d;
  assign rsp_o.press_kind = kind;

endmodule

FILE: rtl/button_debounce_press_classifier.sv
// Top level of the button debounce / press classifier.
// Depends on bdpc_pkg, bdpc_cfg_regs and bdpc_core.
//
// Usage:
//  - Request channel (in_valid_i/in_ready_o/in_data_i): one poll per request,
//    raw pin level plus a free-running millisecond timestamp.
//  - Response channel (out_valid_o/out_ready_i/out_data_o): exactly one
//    response per request, in order: debounced state and press kind
//    (none, short, long, extra long) reported on release.
//  - Config port (cfg_we_i/cfg_idx_i/cfg_wdata_i): single-cycle writes,
//    only while no request is in flight.
//  - Path: the input register loads at the accepting edge, the result
//    register loads from bdpc_core once it is free. Throughput: one request
//    per cycle while the receiver does not stall.
//  - Reset: state cleared to not pressed, no debounce window open,
//    registers back to their defaults, both pipeline stages empty.
//  - Receiver stall: the result register holds; the input register keeps
//    accepting until it is also full, then in_ready_o drops.
module button_debounce_press_classifier
  import bdpc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  bdpc_req_t               in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output bdpc_rsp_t               out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  bdpc_cfg_t cfg;
  bdpc_rsp_t rsp;

  logic      s1_valid_q;
  bdpc_req_t s1_data_q;
  logic      out_valid_q;
  bdpc_rsp_t out_data_q;

  logic out_free;
  logic step;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  bdpc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdpc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (s1_data_q),
    .cfg_i  (cfg),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_debounce_press_classifier.
// Uses bdpc_pkg types. Drives polls, predicts each response in-bench and compares.
module tb;
  import bdpc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  bdpc_req_t               in_data   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  bdpc_rsp_t               out_data;
  logic                    cfg_we    = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx   = CFG_IDX_DEBOUNCE;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;

  // predictor state
  bdpc_cfg_t   cfg_shadow;
  logic        btn_acc;
  logic        btn_prior;
  logic        db_open;
  logic [31:0] db_start;
  logic [31:0] press_t0;

  bdpc_rsp_t   expected_rsp_q[$];
  logic [31:0] poll_t;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned n_polls       = 0;
  int unsigned n_checked     = 0;
  int unsigned n_errors      = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};

  button_debounce_press_classifier u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic bdpc_rsp_t classify_poll(bdpc_req_t req);
    bdpc_rsp_t   rsp;
    logic        flag;
    logic [31:0] span;
    flag = (req.pin_level == cfg_shadow.pressed_level);
    span = req.now_ms - db_start;
    if (flag != btn_acc && !db_open) begin
      db_open  = 1'b1;
      db_start = req.now_ms;
    end else if (db_open && span < {16'd0, cfg_shadow.debounce_ms}) begin
      if (flag == btn_acc) db_open = 1'b0;
    end else begin
      db_open   = 1'b0;
      btn_prior = btn_acc;
      btn_acc   = flag;
    end
    rsp.pressed    = btn_acc;
    rsp.press_kind = KIND_NONE;
    span = req.now_ms - press_t0;
    if (btn_acc && !btn_prior) begin
      press_t0 = req.now_ms;
    end else if (!btn_acc && btn_prior) begin
      if (span > {16'd0, cfg_shadow.extra_long_press_ms}) rsp.press_kind = KIND_EXTRA_LONG;
      else if (span > {16'd0, cfg_shadow.long_press_ms})  rsp.press_kind = KIND_LONG;
      else                                                 rsp.press_kind = KIND_SHORT;
    end
    return rsp;
  endfunction

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("MISMATCH response %0d %s: expected %0d, actual %0d", n_checked, what, want, got);
  endfunction

  always @(posedge clk) begin : check_rsp
    bdpc_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        note_mismatch("unexpected response, pressed", 0, out_data.pressed);
      end else begin
        want = expected_rsp_q.pop_front();
        kind_count[want.press_kind]++;
        if (out_data.pressed !== want.pressed)
          note_mismatch("pressed", want.pressed, out_data.pressed);
        if (out_data.press_kind !== want.press_kind)
          note_mismatch("press_kind", want.press_kind, out_data.press_kind);
        n_checked++;
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d responses outstanding",
             LIMIT_CYCLES, expected_rsp_q.size());
    $display("tb failed");
    $finish;
  end

  function automatic void set_idling(int unsigned send_pct, int unsigned rcv_pct);
    send_idle_pct = send_pct;
    stall_pct     = rcv_pct;
  endfunction

  task automatic send_poll(input logic pin, input logic [31:0] stamp);
    bdpc_req_t req;
    req.pin_level = pin;
    req.now_ms    = stamp;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    expected_rsp_q.push_back(classify_poll(req));
    n_polls++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_IDX_DEBOUNCE:   cfg_shadow.debounce_ms         = val;
      CFG_IDX_LONG:       cfg_shadow.long_press_ms       = val;
      CFG_IDX_EXTRA_LONG: cfg_shadow.extra_long_press_ms = val;
      CFG_IDX_LEVEL:      cfg_shadow.pressed_level       = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [15:0] db, input logic [15:0] lng,
                              input logic [15:0] xlng, input logic lvl);
    wait_quiet();
    write_reg(CFG_IDX_DEBOUNCE, db);
    write_reg(CFG_IDX_LONG, lng);
    write_reg(CFG_IDX_EXTRA_LONG, xlng);
    write_reg(CFG_IDX_LEVEL, {15'd0, lvl});
  endtask

  function automatic logic [31:0] pick_hold();
    logic [31:0] lng;
    logic [31:0] xlng;
    lng  = {16'd0, cfg_shadow.long_press_ms};
    xlng = {16'd0, cfg_shadow.extra_long_press_ms};
    case ($urandom_range(0, 7))
      0:       return lng;
      1:       return lng + 1;
      2:       return xlng;
      3:       return xlng + 1;
      4:       return $urandom_range(0, lng);
      5:       return $urandom_range(0, xlng + 100);
      6:       return $urandom_range(0, 70000);
      default: return $urandom_range(0, 200000);
    endcase
  endfunction

  // bounce, press, hold for a chosen time, release through a full window
  task automatic press_episode();
    logic        p;
    logic [31:0] db;
    logic [31:0] hold;
    logic [31:0] rel;
    p  = cfg_shadow.pressed_level;
    db = {16'd0, cfg_shadow.debounce_ms};
    if (btn_acc || db_open) begin
      poll_t += 1;
      send_poll(~p, poll_t);
      poll_t += db;
      send_poll(~p, poll_t);
    end
    repeat ($urandom_range(0, 4)) begin
      poll_t += $urandom_range(0, db / 2);
      send_poll(1'($urandom_range(0, 1)), poll_t);
    end
    poll_t += $urandom_range(1, 5);
    send_poll(p, poll_t);
    poll_t += db;
    send_poll(p, poll_t);
    hold = pick_hold();
    if (hold < 2 * db) hold = 2 * db;
    rel = press_t0 + hold - db;
    repeat ($urandom_range(0, 3)) begin
      poll_t += $urandom_range(0, (rel - poll_t) / 2);
      send_poll(p, poll_t);
    end
    poll_t = rel;
    send_poll(~p, poll_t);
    if (db > 1) begin
      repeat ($urandom_range(0, 2)) begin
        poll_t += $urandom_range(0, rel + db - 1 - poll_t);
        send_poll(~p, poll_t);
      end
    end
    poll_t = rel + db;
    send_poll(~p, poll_t);
    repeat ($urandom_range(0, 2)) begin
      poll_t += $urandom_range(0, db + 5);
      send_poll(~p, poll_t);
    end
  endtask

  task automatic noise_burst();
    logic [31:0] db;
    db = {16'd0, cfg_shadow.debounce_ms};
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 9) == 0) poll_t += $urandom;
      else                           poll_t += $urandom_range(0, db + 3);
      send_poll(1'($urandom_range(0, 1)), poll_t);
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    stop_at = n_polls + n;
    while (n_polls < stop_at) begin
      if ($urandom_range(0, 4) == 0) noise_burst();
      else                           press_episode();
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_poll(1'b0, 32'd0);
    send_poll(1'b1, 32'd10);
    send_poll(1'b0, 32'd15);           // bounce dropped
    send_poll(1'b1, 32'd100);
    send_poll(1'b1, 32'd119);
    send_poll(1'b1, 32'd120);          // press accepted
    send_poll(1'b0, 32'd500);
    send_poll(1'b0, 32'd520);          // short
    send_poll(1'b1, 32'd1000);
    send_poll(1'b1, 32'd1020);
    send_poll(1'b0, 32'd2100);
    send_poll(1'b0, 32'd2121);         // short (press start restamped at 2100)
    send_poll(1'b1, 32'd3000);
    send_poll(1'b1, 32'd3020);
    send_poll(1'b0, 32'd4000);
    send_poll(1'b0, 32'd4020);         // short (press start restamped at 4000)
    send_poll(1'b1, 32'hFFFF_F000);
    send_poll(1'b1, 32'hFFFF_F014);
    send_poll(1'b0, 32'h0000_0800);
    send_poll(1'b0, 32'h0000_0814);    // short: press spans the time wrap
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'hFFFF_FFFF);
    poll_t = 32'hFFFF_FFFF;
  endtask

  task automatic test_zero_timing();
    apply_config(16'd0, 16'd0, 16'd0, 1'b1);
    set_idling(75, 0);
    poll_t = $urandom;
    run_random(200);
  endtask

  task automatic test_max_timing();
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    set_idling(0, 75);
    poll_t = $urandom;
    run_random(200);
  endtask

  task automatic test_swapped_thresholds();
    apply_config(16'd10, 16'd3000, 16'd400, 1'b0);
    set_idling(18, 18);
    poll_t = $urandom;
    run_random(200);
  endtask

  task automatic test_sender_pause();
    apply_config(16'd20, 16'd1000, 16'd3000, 1'b1);
    set_idling(0, 0);
    run_random(100);
    wait_quiet();
    run_random(100);
  endtask

  task automatic test_random_config();
    for (int i = 0; i < 4; i++) begin
      apply_config(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 40)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
      case (i)
        0:       set_idling(0, 0);
        1:       set_idling(75, 0);
        2:       set_idling(0, 75);
        default: set_idling(18, 18);
      endcase
      poll_t = $urandom;
      run_random(230);
    end
  endtask

  initial begin
    cfg_shadow = '{DEBOUNCE_MS_RST, LONG_PRESS_MS_RST, XLONG_PRESS_MS_RST, PRESSED_LEVEL_RST};
    btn_acc    = 1'b0;
    btn_prior  = 1'b0;
    db_open    = 1'b0;
    db_start   = '0;
    press_t0   = '0;
    poll_t     = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_zero_timing();
    test_max_timing();
    test_swapped_thresholds();
    test_sender_pause();
    test_random_config();

    wait_quiet();
    repeat (10) @(posedge clk);
    $display("Covered %0d polls over 9 register settings; %0d responses checked, %0d errors",
             n_polls, n_checked, n_errors);
    $display("Releases classified: short %0d, long %0d, extra long %0d",
             kind_count[KIND_SHORT], kind_count[KIND_LONG], kind_count[KIND_EXTRA_LONG]);
    if (n_errors == 0 && expected_rsp_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
